/* rtl/unorm_quantization_error_meter_defines.svh */
// Assertion macros shared by the quantization error meter RTL.
`ifndef UNORM_QUANTIZATION_ERROR_METER_DEFINES_SVH
`define UNORM_QUANTIZATION_ERROR_METER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define UQEM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UQEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/uqem_pkg.sv */
// Shared types and constants of the quantization error meter.
package uqem_pkg;

   // Width of the saturating vertex counter.
   localparam int COUNT_WIDTH = 32;
   // Divisor width of the restoring dividers.
   localparam int DEN_W = (COUNT_WIDTH > 34) ? COUNT_WIDTH : 34;
   // Number of axis lanes.
   localparam int LANES = 3;
   // Widest unorm code.
   localparam int MAX_BITS = 16;

   typedef enum logic [2:0] {
      CSR_BIT_COUNT = 3'd0,
      CSR_SCALE_X   = 3'd1,
      CSR_SCALE_Y   = 3'd2,
      CSR_SCALE_Z   = 3'd3,
      CSR_OFFSET_X  = 3'd4,
      CSR_OFFSET_Y  = 3'd5,
      CSR_OFFSET_Z  = 3'd6
   } csr_index_type;

endpackage

/* rtl/unorm_quantization_error_meter.sv */
// Top level of the unorm quantization error meter.
//
// Each req beat carries one vertex (three signed Q16.16 positions). Three axis
// lanes work side by side: each normalizes its position by the axis offset and
// scale, rounds it half up to an N-bit unorm code (N from bit_count), rebuilds
// the position and measures the absolute error, rounded to Q16.16 and
// saturated to 32 bits, and its square. A merge stage then folds the three
// squares into a saturating Q32.32 sum, tracks the peak error and counts the
// vertex. On a beat with tlast set, one rsp beat follows with the sum divided
// by the count and the peak, and the running state clears. The block works on
// one vertex at a time: every lane runs up to two restoring divisions of a
// 64-bit dividend (the rounded quantization, skipped when the position is not
// above the offset, and the rounded error), and req_tready stays low until
// the merge is done; a last vertex adds a restoring division for the mean. A
// finished result sits in the rsp output register while the next vertex is
// taken. Configuration writes are applied at once and are only to be made
// while no vertex is in flight.
`include "unorm_quantization_error_meter_defines.svh"

module unorm_quantization_error_meter
   import uqem_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Vertex input.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
   input  logic        req_tlast,   // last_vertex
   // Result output.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // mean_sq_error [63:0], max_abs_error [95:64]
   // Configuration writes.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [2:0] {
      T_IDLE  = 3'b001,
      T_LANES = 3'b010,
      T_MERGE = 3'b100
   } top_state_type;

   top_state_type                state_ff, state_in;
   logic [4:0]                   bit_count_ff;
   logic [LANES-1:0][31:0]       scale_ff;
   logic [LANES-1:0][31:0]       offset_ff;
   logic [MAX_BITS-1:0]          m_ff;
   logic [MAX_BITS-1:0]          m_in;
   logic [4:0]                   n_clamped;
   logic                         accept;
   logic                         merge_start;
   logic                         merge_done;
   logic [LANES-1:0]             lane_done;
   logic [LANES-1:0][31:0]       lane_abs;
   logic [LANES-1:0][63:0]       lane_sq;
   logic [LANES-1:0][31:0]       lane_pos;
   logic                         last_ff;

   assign req_tready = (state_ff == T_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign lane_pos   = req_tdata;

   // A bit count of zero acts as one, anything above sixteen as sixteen.
   always_comb begin
      if (bit_count_ff == 5'd0) begin
         n_clamped = 5'd1;
      end else if (bit_count_ff > 5'(MAX_BITS)) begin
         n_clamped = 5'(MAX_BITS);
      end else begin
         n_clamped = bit_count_ff;
      end
      m_in = MAX_BITS'((17'd1 << n_clamped) - 17'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= 5'd16;
         scale_ff     <= {LANES{32'd65536}};
         offset_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BIT_COUNT: bit_count_ff <= csr_wdata[4:0];
            CSR_SCALE_X:   scale_ff[0]  <= csr_wdata;
            CSR_SCALE_Y:   scale_ff[1]  <= csr_wdata;
            CSR_SCALE_Z:   scale_ff[2]  <= csr_wdata;
            CSR_OFFSET_X:  offset_ff[0] <= csr_wdata;
            CSR_OFFSET_Y:  offset_ff[1] <= csr_wdata;
            CSR_OFFSET_Z:  offset_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The unorm maximum is fixed for the whole vertex.
   always_ff @(posedge clock) begin
      if (accept) begin
         m_ff    <= m_in;
         last_ff <= req_tlast;
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      uqem_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .start   (accept),
         .pos     (lane_pos[g]),
         .scale   (scale_ff[g]),
         .offset  (offset_ff[g]),
         .m       (m_ff),
         .done    (lane_done[g]),
         .abs_err (lane_abs[g]),
         .sq_err  (lane_sq[g])
      );
   end

   assign merge_start = (state_ff == T_LANES) && (&lane_done);

   uqem_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .start      (merge_start),
      .last       (last_ff),
      .abs_err    (lane_abs),
      .sq_err     (lane_sq),
      .done       (merge_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               state_in = T_LANES;
            end
         end
         T_LANES: begin
            if (merge_start) begin
               state_in = T_MERGE;
            end
         end
         T_MERGE: begin
            if (merge_done) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A new result can only appear while a last vertex is being merged.
   `UQEM_ASSERT_NOW(a_rsp_from_last, clock, reset, $rose(rsp_tvalid), $past(state_ff == T_MERGE) && last_ff, "result raised outside a last-vertex merge")
   // The lanes restart on every accepted vertex, so none can report done next cycle.
   `UQEM_ASSERT_NEXT(a_lanes_restart, clock, reset, accept, lane_done == '0, "lane still done after a new vertex")
   // The merge never completes while the lanes are still working.
   `UQEM_ASSERT_NOW(a_merge_after_lanes, clock, reset, merge_done, state_ff == T_MERGE, "merge finished outside the merge phase")
   // The unorm maximum used by a vertex never changes while it is in flight.
   `UQEM_ASSERT_NEXT(a_m_stable, clock, reset, state_ff == T_LANES, $stable(m_ff), "unorm maximum changed during a vertex")

endmodule

/* rtl/uqem_div.sv */
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
module uqem_div
   import uqem_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [63:0]      numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [63:0]      quot
);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [63:0]      num_ff, num_in;
   logic [63:0]      quot_ff, quot_in;
   logic [DEN_W-1:0] den_ff;
   logic [6:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_shift;
   logic             fits;

   always_comb begin
      rem_shift = {rem_ff, num_ff[63]};
      fits      = rem_shift >= {1'b0, den_ff};
      rem_in    = rem_ff;
      num_in    = num_ff;
      quot_in   = quot_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in  = '0;
         num_in  = numer;
         quot_in = '0;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DEN_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DEN_W-1:0];
         num_in  = {num_ff[62:0], 1'b0};
         quot_in = {quot_ff[62:0], fits};
         cnt_in  = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      if (start) begin
         den_ff <= denom;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* rtl/uqem_lane.sv */
// One axis lane: quantize, reconstruct, absolute and squared error.
module uqem_lane
   import uqem_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [31:0]         pos,
   input  logic [31:0]         scale,
   input  logic [31:0]         offset,
   input  logic [MAX_BITS-1:0] m,
   output logic                done,
   output logic [31:0]         abs_err,
   output logic [63:0]         sq_err
);

   typedef enum logic [8:0] {
      L_IDLE  = 9'b000000001,
      L_DM    = 9'b000000010,
      L_LOAD1 = 9'b000000100,
      L_DIV1  = 9'b000001000,
      L_QS    = 9'b000010000,
      L_LOAD2 = 9'b000100000,
      L_DIV2  = 9'b001000000,
      L_SQ    = 9'b010000000,
      L_DONE  = 9'b100000000
   } lane_state_type;

   lane_state_type      state_ff, state_in;
   logic signed [32:0]  d_ff;
   logic [31:0]         s_ff;
   logic signed [49:0]  dm_ff;
   logic [15:0]         q_ff, q_in;
   logic [47:0]         qs_ff;
   logic [31:0]         a_ff, a_in;
   logic [63:0]         sq_ff;
   logic                div_start;
   logic [63:0]         div_numer;
   logic [DEN_W-1:0]    div_denom;
   logic                div_done;
   logic [63:0]         div_quot;
   logic signed [50:0]  diff;
   logic [49:0]         mag;
   logic                d_nonpos;

   uqem_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      d_nonpos = d_ff[32] || (d_ff == '0);
      // Reconstruction error times M: q*scale - d*M.
      diff = $signed({3'b000, qs_ff}) - $signed({dm_ff[49], dm_ff});
      mag  = diff[50] ? 50'(-diff) : diff[49:0];
      div_start = 1'b0;
      div_numer = '0;
      div_denom = '0;
      state_in  = state_ff;
      q_in      = q_ff;
      a_in      = a_ff;
      unique case (state_ff)
         L_IDLE, L_DONE: begin
            if (start) begin
               state_in = L_DM;
            end
         end
         L_DM: begin
            state_in = L_LOAD1;
         end
         L_LOAD1: begin
            if (d_nonpos) begin
               q_in     = '0;
               state_in = L_QS;
            end else begin
               // Round half up: (2*d*M + s) / (2*s).
               div_start = 1'b1;
               div_numer = ({15'd0, dm_ff[48:0]} << 1) + {32'd0, s_ff};
               div_denom = DEN_W'({s_ff, 1'b0});
               state_in  = L_DIV1;
            end
         end
         L_DIV1: begin
            if (div_done) begin
               q_in     = (div_quot > 64'(m)) ? m : div_quot[15:0];
               state_in = L_QS;
            end
         end
         L_QS: begin
            state_in = L_LOAD2;
         end
         L_LOAD2: begin
            // Magnitude in Q16.16, rounded half up: (2*mag + M) / (2*M).
            div_start = 1'b1;
            div_numer = ({14'd0, mag} << 1) + 64'(m);
            div_denom = DEN_W'({m, 1'b0});
            state_in  = L_DIV2;
         end
         L_DIV2: begin
            if (div_done) begin
               a_in     = (div_quot > 64'hFFFF_FFFF) ? '1 : div_quot[31:0];
               state_in = L_SQ;
            end
         end
         L_SQ: begin
            state_in = L_DONE;
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (start) begin
         d_ff <= $signed({pos[31], pos}) - $signed({offset[31], offset});
         s_ff <= (scale == '0) ? 32'd1 : scale;
      end
      if (state_ff == L_DM) begin
         dm_ff <= d_ff * $signed({1'b0, m});
      end
      if (state_ff == L_QS) begin
         qs_ff <= 48'(q_ff) * 48'(s_ff);
      end
      if (state_ff == L_SQ) begin
         sq_ff <= 64'(a_ff) * 64'(a_ff);
      end
      q_ff <= q_in;
      a_ff <= a_in;
   end

   assign done    = (state_ff == L_DONE);
   assign abs_err = a_ff;
   assign sq_err  = sq_ff;

endmodule

/* rtl/uqem_merge.sv */
// Merges lane errors into the running sums and produces the mean on the last vertex.
module uqem_merge
   import uqem_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   last,
   input  logic [LANES-1:0][31:0] abs_err,
   input  logic [LANES-1:0][63:0] sq_err,
   output logic                   done,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [95:0]            rsp_tdata
);

   typedef enum logic [5:0] {
      M_IDLE  = 6'b000001,
      M_ACC   = 6'b000010,
      M_CNT   = 6'b000100,
      M_DLOAD = 6'b001000,
      M_DIV   = 6'b010000,
      M_OUT   = 6'b100000
   } merge_state_type;

   merge_state_type        state_ff, state_in;
   logic [63:0]            sum_ff, sum_in;
   logic [31:0]            peak_ff, peak_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   last_ff;
   logic                   done_ff, done_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [95:0]            rsp_data_ff, rsp_data_in;
   logic [64:0]            sum_wide;
   logic                   div_start;
   logic                   div_done;
   logic [63:0]            div_quot;

   uqem_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (sum_ff),
      .denom (DEN_W'(count_ff)),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      sum_wide     = {1'b0, sum_ff} + {1'b0, sq_err[idx_ff]};
      state_in     = state_ff;
      sum_in       = sum_ff;
      peak_in      = peak_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      done_in      = 1'b0;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         M_IDLE: begin
            if (start) begin
               idx_in   = '0;
               state_in = M_ACC;
            end
         end
         M_ACC: begin
            // One lane per cycle; the sum sticks at all ones.
            sum_in  = sum_wide[64] ? '1 : sum_wide[63:0];
            peak_in = (abs_err[idx_ff] > peak_ff) ? abs_err[idx_ff] : peak_ff;
            idx_in  = idx_ff + 2'd1;
            if (idx_ff == 2'(LANES - 1)) begin
               state_in = M_CNT;
            end
         end
         M_CNT: begin
            count_in = (count_ff == '1) ? count_ff : count_ff + 1'b1;
            if (last_ff) begin
               state_in = M_DLOAD;
            end else begin
               done_in  = 1'b1;
               state_in = M_IDLE;
            end
         end
         M_DLOAD: begin
            div_start = 1'b1;
            state_in  = M_DIV;
         end
         M_DIV: begin
            if (div_done) begin
               state_in = M_OUT;
            end
         end
         M_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {peak_ff, div_quot};
               sum_in       = '0;
               peak_in      = '0;
               count_in     = '0;
               done_in      = 1'b1;
               state_in     = M_IDLE;
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= M_IDLE;
         sum_ff       <= '0;
         peak_ff      <= '0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         peak_ff      <= peak_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      if (start) begin
         last_ff <= last;
      end
   end

   assign done       = done_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
